// ----- rtl/spe_pkg.sv -----
// ----------------------------------------------------------------------------
// spe_pkg
// shared constants and types of the shortest path engine
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int MAX_NODES = 8;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
	localparam int MAT_AW    = 2 * NODE_W;
	localparam int LEN_W     = 20;
	localparam int SUM_W     = LEN_W + 1;
	localparam int PAR_W     = 4;
	localparam int CNT_W     = 4;
	localparam int WGT_W     = 16;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [LEN_W-1:0] INF_LEN    = {LEN_W{1'b1}};
	localparam logic [WGT_W-1:0] NO_EDGE_IN = {WGT_W{1'b1}};
	localparam logic [PAR_W-1:0] NO_PARENT  = PAR_W'(MAX_NODES);
	localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_NODES);

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_WRITE    = 2'd1,
		OP_DIJKSTRA = 2'd2,
		OP_FLOYD    = 2'd3
	} opcode_t;

	typedef enum logic {
		REG_NODE_COUNT = 1'b0,
		REG_UNDIRECTED = 1'b1
	} reg_index_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [NODE_W-1:0]   from_node;
		logic [NODE_W-1:0]   to_node;
		logic [WGT_W-1:0]    edge_weight;
	} cmd_word_t;

	typedef struct packed {
		logic [NODE_W-1:0]   row_node;
		logic [NODE_W-1:0]   column_node;
		logic [LEN_W-1:0]    path_length;
		logic [PAR_W-1:0]    parent_node;
		logic                last_result;
	} res_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]    node_count;
		logic                undirected_mode;
	} cfg_t;

	typedef struct packed {
		logic                en;
		logic [MAT_AW-1:0]   addr;
		logic [LEN_W-1:0]    data;
	} mat_wr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR2,
		ST_DJ_INIT,
		ST_DJ_SCAN,
		ST_DJ_RELAX,
		ST_DJ_DRAIN,
		ST_FW_IK,
		ST_FW_IKCHK,
		ST_FW_J,
		ST_FW_DRAIN,
		ST_EM_RD,
		ST_EM_WR
	} state_t;

endpackage

// ----- rtl/shortest_path_engine_top.sv -----
// ----------------------------------------------------------------------------
// shortest_path_engine_top
// adjacency matrix shortest path engine, dijkstra and floyd-warshall
// ----------------------------------------------------------------------------
// Commands are taken one at a time; cmd_stall is high while a command is at
// work. Clear needs no clearing pass (per-entry valid bits), and a mirrored
// edge write adds a second write state. The run time of Dijkstra and
// Floyd-Warshall is set by one adder and comparator shared by all
// relaxations and by the matrix ram's two read ports with registered data.
// Results leave through an output register that holds while res_stall is
// high.
module shortest_path_engine_top import spe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  cmd_word_t          cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output res_word_t          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t              cfg;
	state_t            state_q, state_d;
	logic              accept;
	logic [CNT_W-1:0]  act;
	logic [NODE_W-1:0] last_idx;
	logic              src_ok;

	logic              dj_q;
	logic [NODE_W-1:0] src_q;
	logic [MAT_AW-1:0] mir_addr_q;
	logic [LEN_W-1:0]  mir_val_q;
	logic [NODE_W-1:0] ii_q, jj_q, kk_q, er_q, ec_q;
	logic [NODE_W-1:0] sel_q;
	logic [LEN_W-1:0]  dsel_q, best_q, ik_q;
	logic [LEN_W-1:0]  dist_q [MAX_NODES];
	logic [PAR_W-1:0]  par_q  [MAX_NODES];
	logic [MAX_NODES-1:0] vis_q;
	logic              pv_s1;
	logic [NODE_W-1:0] pj_s1;

	logic              mat_clear;
	mat_wr_t           mat_wr;
	logic [MAT_AW-1:0] raddr_a, raddr_b;
	logic [LEN_W-1:0]  rd_a, rd_b;
	logic              issue;
	logic              load_out;
	logic              out_free;
	res_word_t         res_q;
	logic              res_valid_q;

	logic [LEN_W-1:0]  op_a, cmp_ref;
	logic [SUM_W-1:0]  sum;
	logic              better;
	logic              upd;
	logic [NODE_W-1:0] nsel;
	logic [LEN_W-1:0]  edge_val;
	logic              fw_end, em_end;

	spe_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	spe_matrix u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (mat_clear),
		.wr     (mat_wr),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// active node count, clamped into 1..MAX_NODES
	always_comb begin
		if (cfg.node_count == '0) begin
			act = CNT_W'(1);
		end else if (cfg.node_count > CNT_MAX) begin
			act = CNT_MAX;
		end else begin
			act = cfg.node_count;
		end
	end

	assign last_idx  = NODE_W'(act - CNT_W'(1));
	assign src_ok    = {1'b0, src_q} < act;
	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign fw_end    = (ii_q == last_idx) && (kk_q == last_idx);
	assign em_end    = (ec_q == last_idx) && (dj_q || er_q == last_idx);
	assign edge_val  = (cmd.edge_weight == NO_EDGE_IN) ? INF_LEN
	                                                   : LEN_W'(cmd.edge_weight);

	// shared adder and comparator
	assign op_a    = dj_q ? dsel_q : ik_q;
	assign cmp_ref = dj_q ? dist_q[pj_s1] : rd_b;
	assign sum     = {1'b0, op_a} + {1'b0, rd_a};
	assign better  = (rd_a != INF_LEN) && (sum < {1'b0, cmp_ref});

	// minimum search, one node a cycle
	assign upd  = !vis_q[ii_q] && (dist_q[ii_q] < best_q);
	assign nsel = upd ? ii_q : sel_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.opcode)
						OP_CLEAR:    state_d = ST_IDLE;
						OP_WRITE:    state_d = cfg.undirected_mode ? ST_WR2 : ST_IDLE;
						OP_DIJKSTRA: state_d = ST_DJ_INIT;
						OP_FLOYD:    state_d = ST_FW_IK;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR2:      state_d = ST_IDLE;
			ST_DJ_INIT:  state_d = src_ok ? ST_DJ_SCAN : ST_EM_RD;
			ST_DJ_SCAN:  if (ii_q == last_idx) state_d = ST_DJ_RELAX;
			ST_DJ_RELAX: if (ii_q == last_idx) state_d = ST_DJ_DRAIN;
			ST_DJ_DRAIN: state_d = (kk_q == last_idx) ? ST_EM_RD : ST_DJ_SCAN;
			ST_FW_IK:    state_d = ST_FW_IKCHK;
			ST_FW_IKCHK: begin
				if (rd_a != INF_LEN) begin
					state_d = ST_FW_J;
				end else begin
					state_d = fw_end ? ST_EM_RD : ST_FW_IK;
				end
			end
			ST_FW_J:     if (jj_q == last_idx) state_d = ST_FW_DRAIN;
			ST_FW_DRAIN: state_d = fw_end ? ST_EM_RD : ST_FW_IK;
			ST_EM_RD:    if (out_free) state_d = ST_EM_WR;
			ST_EM_WR:    state_d = em_end ? ST_IDLE : ST_EM_RD;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mat_clear = 1'b0;
		mat_wr    = '0;
		raddr_a   = '0;
		raddr_b   = '0;
		issue     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd.opcode == OP_CLEAR) begin
					mat_clear = 1'b1;
				end
				if (accept && cmd.opcode == OP_WRITE) begin
					mat_wr.en   = 1'b1;
					mat_wr.addr = {cmd.from_node, cmd.to_node};
					mat_wr.data = edge_val;
				end
			end
			ST_WR2: begin
				mat_wr.en   = 1'b1;
				mat_wr.addr = mir_addr_q;
				mat_wr.data = mir_val_q;
			end
			ST_DJ_RELAX: begin
				raddr_a = {sel_q, ii_q};
				issue   = 1'b1;
			end
			ST_FW_IK: begin
				raddr_a = {ii_q, kk_q};
			end
			ST_FW_J: begin
				raddr_a = {kk_q, jj_q};
				raddr_b = {ii_q, jj_q};
				issue   = 1'b1;
			end
			ST_EM_RD: begin
				raddr_a = {er_q, ec_q};
			end
			ST_EM_WR: begin
				load_out = 1'b1;
			end
			default: ;
		endcase
		// floyd-warshall write back of the previous column
		if (pv_s1 && !dj_q && better) begin
			mat_wr.en   = 1'b1;
			mat_wr.addr = {ii_q, pj_s1};
			mat_wr.data = sum[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			pv_s1       <= 1'b0;
			ii_q        <= '0;
			jj_q        <= '0;
			kk_q        <= '0;
			er_q        <= '0;
			ec_q        <= '0;
		end else begin
			state_q <= state_d;
			pv_s1   <= issue;
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					ii_q <= '0;
					jj_q <= '0;
					kk_q <= '0;
					er_q <= '0;
					ec_q <= '0;
				end
				ST_DJ_SCAN, ST_DJ_RELAX: begin
					ii_q <= (ii_q == last_idx) ? '0 : ii_q + NODE_W'(1);
				end
				ST_DJ_DRAIN: begin
					kk_q <= kk_q + NODE_W'(1);
				end
				ST_FW_IKCHK, ST_FW_DRAIN: begin
					jj_q <= '0;
					if (state_q == ST_FW_DRAIN || rd_a == INF_LEN) begin
						if (ii_q == last_idx) begin
							ii_q <= '0;
							kk_q <= kk_q + NODE_W'(1);
						end else begin
							ii_q <= ii_q + NODE_W'(1);
						end
					end
				end
				ST_FW_J: begin
					jj_q <= jj_q + NODE_W'(1);
				end
				ST_EM_WR: begin
					if (ec_q == last_idx) begin
						ec_q <= '0;
						er_q <= er_q + NODE_W'(1);
					end else begin
						ec_q <= ec_q + NODE_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pj_s1 <= (state_q == ST_FW_J) ? jj_q : ii_q;
		if (accept) begin
			dj_q       <= (cmd.opcode == OP_DIJKSTRA);
			src_q      <= cmd.from_node;
			mir_addr_q <= {cmd.to_node, cmd.from_node};
			mir_val_q  <= edge_val;
		end
		if (state_q == ST_FW_IKCHK) begin
			ik_q <= rd_a;
		end
		if (state_q == ST_DJ_INIT) begin
			// the source starts at distance zero and is its own parent
			for (int i = 0; i < MAX_NODES; i++) begin
				dist_q[i] <= (src_ok && NODE_W'(i) == src_q) ? '0 : INF_LEN;
				par_q[i]  <= (src_ok && NODE_W'(i) == src_q) ? PAR_W'(src_q)
				                                             : NO_PARENT;
			end
			vis_q  <= '0;
			best_q <= INF_LEN;
			sel_q  <= '0;
		end
		if (state_q == ST_DJ_SCAN) begin
			if (upd) begin
				best_q <= dist_q[ii_q];
				dsel_q <= dist_q[ii_q];
				sel_q  <= ii_q;
			end
			if (ii_q == last_idx) begin
				vis_q[nsel] <= 1'b1;
			end
		end
		if (state_q == ST_DJ_DRAIN) begin
			best_q <= INF_LEN;
		end
		// dijkstra relaxation of the previous node
		if (pv_s1 && dj_q && better) begin
			dist_q[pj_s1] <= sum[LEN_W-1:0];
			par_q[pj_s1]  <= PAR_W'(sel_q);
		end
		if (load_out) begin
			res_q.row_node    <= dj_q ? src_q : er_q;
			res_q.column_node <= ec_q;
			res_q.path_length <= dj_q ? dist_q[ec_q] : rd_a;
			res_q.parent_node <= dj_q ? par_q[ec_q] : NO_PARENT;
			res_q.last_result <= em_end;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/spe_ram.sv -----
// ----------------------------------------------------------------------------
// spe_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module spe_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/spe_matrix.sv -----
// ----------------------------------------------------------------------------
// spe_matrix
// weight matrix: ram plus per-entry valid bits, invalid entries read as infinity
// ----------------------------------------------------------------------------
module spe_matrix import spe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  mat_wr_t           wr,
	input  logic [MAT_AW-1:0] raddr_a,
	input  logic [MAT_AW-1:0] raddr_b,
	output logic [LEN_W-1:0]  rdata_a,
	output logic [LEN_W-1:0]  rdata_b
);

	logic [MAT_DEPTH-1:0] valid_q;
	logic                 vld_a_q;
	logic                 vld_b_q;
	logic [LEN_W-1:0]     ram_a;
	logic [LEN_W-1:0]     ram_b;

	spe_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MAT_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (wr.en),
		.waddr  (wr.addr),
		.wdata  (wr.data),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(ram_a),
		.rdata_b(ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vld_a_q <= valid_q[raddr_a];
		vld_b_q <= valid_q[raddr_b];
	end

	assign rdata_a = vld_a_q ? ram_a : INF_LEN;
	assign rdata_b = vld_b_q ? ram_b : INF_LEN;

endmodule

// ----- rtl/spe_cfg.sv -----
// ----------------------------------------------------------------------------
// spe_cfg
// apb register file: node count and undirected mode
// ----------------------------------------------------------------------------
module spe_cfg import spe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	reg_index_t idx;

	assign idx    = reg_index_t'(paddr[2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_count      <= CNT_MAX;
			cfg_q.undirected_mode <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_NODE_COUNT: cfg_q.node_count      <= pwdata[CNT_W-1:0];
				REG_UNDIRECTED: cfg_q.undirected_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_NODE_COUNT: prdata[CNT_W-1:0] = cfg_q.node_count;
			REG_UNDIRECTED: prdata[0]         = cfg_q.undirected_mode;
			default: ;
		endcase
	end

endmodule

// ----- tb/shortest_path_engine_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_engine_top_tb
// self-checking bench for the adjacency matrix shortest path engine
// ----------------------------------------------------------------------------
// A queue of command words feeds a bursty driver. Every accepted command runs
// through a local copy of the matrix, which predicts the dijkstra and
// floyd-warshall result words. A monitor checks each result word against the
// oldest prediction while the result side stalls on its own pattern. Node
// count and undirected mode are set over apb between phases, when idle.
// ----------------------------------------------------------------------------
module shortest_path_engine_top_tb;
	import spe_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	cmd_word_t          cmd;
	logic               res_valid;
	logic               res_stall;
	res_word_t          res;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	shortest_path_engine_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cmd_word_t pending_cmds[$];
	res_word_t expected_words[$];

	// local copy of the engine state
	logic [LEN_W-1:0] mat_copy[MAT_DEPTH];
	logic [CNT_W-1:0] cfg_nodes;
	logic             cfg_undir;

	int unsigned n_cmds, n_results, n_mismatch, n_phases, n_dj, n_fw;
	int unsigned gap_left, burst_left, idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned active_count();
		if (cfg_nodes == 0) return 1;
		if (cfg_nodes > MAX_NODES) return MAX_NODES;
		return cfg_nodes;
	endfunction

	function automatic res_word_t make_word(int unsigned r, int unsigned c,
		int unsigned len, int unsigned par, bit last);
		res_word_t o;
		o.row_node    = NODE_W'(r);
		o.column_node = NODE_W'(c);
		o.path_length = LEN_W'(len);
		o.parent_node = PAR_W'(par);
		o.last_result = last;
		return o;
	endfunction

	task automatic predict_command(input cmd_word_t c);
		int unsigned n, a, b, sel, best, e, s, ik, kj;
		int unsigned node_dist[MAX_NODES];
		int unsigned par[MAX_NODES];
		bit          seen[MAX_NODES];
		logic [LEN_W-1:0] v;
		n = active_count();
		a = c.from_node;
		b = c.to_node;
		n_cmds++;
		case (c.opcode)
			OP_CLEAR: begin
				foreach (mat_copy[i]) mat_copy[i] = INF_LEN;
			end
			OP_WRITE: begin
				v = (c.edge_weight == NO_EDGE_IN) ? INF_LEN : LEN_W'(c.edge_weight);
				mat_copy[a*MAX_NODES+b] = v;
				if (cfg_undir) mat_copy[b*MAX_NODES+a] = v;
			end
			OP_DIJKSTRA: begin
				n_dj++;
				for (int i = 0; i < n; i++) begin
					node_dist[i] = INF_LEN;
					par[i]  = NO_PARENT;
					seen[i] = 1'b0;
				end
				if (a < n) begin
					sel = 0;
					node_dist[a] = 0;
					par[a]  = a;
					for (int k = 0; k < n; k++) begin
						best = INF_LEN;
						for (int i = 0; i < n; i++)
							if (!seen[i] && node_dist[i] < best) begin
								best = node_dist[i];
								sel = i;
							end
						seen[sel] = 1'b1;
						for (int i = 0; i < n; i++) begin
							e = mat_copy[sel*MAX_NODES+i];
							if (e < INF_LEN) begin
								s = e + node_dist[sel];
								if (s < node_dist[i]) begin
									node_dist[i] = s;
									par[i] = sel;
								end
							end
						end
					end
				end
				for (int i = 0; i < n; i++)
					expected_words.push_back(make_word(a, i, node_dist[i], par[i],
						i + 1 == n));
			end
			default: begin
				n_fw++;
				for (int k = 0; k < n; k++)
					for (int i = 0; i < n; i++) begin
						ik = mat_copy[i*MAX_NODES+k];
						if (ik >= INF_LEN) continue;
						for (int j = 0; j < n; j++) begin
							kj = mat_copy[k*MAX_NODES+j];
							if (kj >= INF_LEN) continue;
							s = ik + kj;
							if (s < mat_copy[i*MAX_NODES+j]) mat_copy[i*MAX_NODES+j] = LEN_W'(s);
						end
					end
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++)
						expected_words.push_back(make_word(i, j, mat_copy[i*MAX_NODES+j],
							NO_PARENT, (i + 1 == n) && (j + 1 == n)));
			end
		endcase
	endtask

	// command driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		cmd_word_t w;
		logic      v;
		if (!arst_n) begin
			cmd_valid  <= 1'b0;
			cmd        <= '0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			v = cmd_valid;
			w = cmd;
			if (cmd_valid && !cmd_stall) begin
				predict_command(cmd);
				v = 1'b0;
			end
			if (!v) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					w = pending_cmds.pop_front();
					v = 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end else begin
						burst_left--;
					end
				end
			end
			cmd_valid <= v;
			cmd       <= w;
		end
	end

	// result side: stall raised at random, independently each cycle
	always @(posedge clk or negedge arst_n) begin
		res_word_t exp_w;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (($urandom_range(0, 511) < 256) && ($urandom_range(0, 3) != 0))
				res_stall <= ($urandom_range(0, 2) == 0);
			else
				res_stall <= 1'b0;
			if (res_valid && !res_stall) begin
				n_results++;
				if (expected_words.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected result word %p", res);
				end else begin
					exp_w = expected_words.pop_front();
					if (res.row_node !== exp_w.row_node || res.column_node !== exp_w.column_node
						|| res.path_length !== exp_w.path_length
						|| res.parent_node !== exp_w.parent_node
						|| res.last_result !== exp_w.last_result) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("mismatch: expected %p, got %p", exp_w, res);
					end
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either channel and no apb access
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d words outstanding", expected_words.size());
			$display("shortest_path_engine_top regression: fail");
			$finish;
		end
	end

	task automatic reg_write(input reg_index_t idx, input logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * idx);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_NODE_COUNT) cfg_nodes = val[CNT_W-1:0];
		else cfg_undir = val[0];
	endtask

	task automatic set_config(input int unsigned nodes, input bit undir);
		reg_write(REG_NODE_COUNT, PDATA_W'(nodes));
		reg_write(REG_UNDIRECTED, PDATA_W'(undir));
		n_phases++;
	endtask

	task automatic add_cmd(input opcode_t op, input int unsigned a, input int unsigned b,
		input int unsigned wt);
		cmd_word_t c;
		c.opcode      = op;
		c.from_node   = NODE_W'(a);
		c.to_node     = NODE_W'(b);
		c.edge_weight = WGT_W'(wt);
		pending_cmds.push_back(c);
	endtask

	// sender holds off until every expected word is back and the engine is idle
	task automatic drain();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || cmd_valid || expected_words.size() != 0);
		repeat (20) @(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	function automatic int unsigned rand_weight();
		case ($urandom_range(0, 5))
			0: return 16'hFFFF;
			1: return $urandom_range(0, 16'hFFFF);
			2: return $urandom_range(16'hF000, 16'hFFFE);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// clear, then writes mixed with runs; a few commands are pure noise
	task automatic random_phase(input int unsigned ncmd);
		int unsigned n;
		n = active_count();
		add_cmd(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
		for (int i = 0; i < ncmd; i++) begin
			case ($urandom_range(0, 9))
				0: add_cmd(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom);
				1, 2: add_cmd(OP_DIJKSTRA, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7)
					: $urandom_range(0, n - 1), $urandom_range(0, 7), $urandom);
				3: add_cmd(OP_FLOYD, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
				default: add_cmd(OP_WRITE, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
					: $urandom_range(0, n - 1), ($urandom_range(0, 7) == 0)
					? $urandom_range(0, 7) : $urandom_range(0, n - 1), rand_weight());
			endcase
		end
	endtask

	initial begin
		int unsigned nodes;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		foreach (mat_copy[i]) mat_copy[i] = INF_LEN;
		cfg_nodes = CNT_MAX;
		cfg_undir = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset state, extremes of weights and nodes
		set_config(8, 0);
		add_cmd(OP_FLOYD, 0, 0, 0);
		add_cmd(OP_DIJKSTRA, 7, 0, 0);
		add_cmd(OP_WRITE, 0, 7, 0);
		add_cmd(OP_WRITE, 7, 3, 16'hFFFE);
		add_cmd(OP_WRITE, 3, 3, 5);
		add_cmd(OP_WRITE, 3, 0, 16'h0010);
		add_cmd(OP_WRITE, 0, 1, 16'hFFFF);
		add_cmd(OP_DIJKSTRA, 0, 0, 0);
		add_cmd(OP_DIJKSTRA, 5, 0, 0);
		add_cmd(OP_FLOYD, 7, 7, 16'hFFFF);
		add_cmd(OP_CLEAR, 7, 7, 16'hFFFF);
		add_cmd(OP_DIJKSTRA, 2, 0, 0);
		drain();
		// undirected, small node count, source beyond count, stored far entries
		set_config(3, 1);
		add_cmd(OP_WRITE, 0, 1, 16'h0020);
		add_cmd(OP_WRITE, 1, 2, 16'h0003);
		add_cmd(OP_WRITE, 2, 6, 16'h0001);
		add_cmd(OP_DIJKSTRA, 7, 0, 0);
		add_cmd(OP_DIJKSTRA, 2, 0, 0);
		add_cmd(OP_FLOYD, 0, 0, 0);
		drain();
		set_config(7, 0);
		add_cmd(OP_DIJKSTRA, 6, 0, 0);
		drain();
		// out of range counts clamp
		set_config(0, 0);
		add_cmd(OP_DIJKSTRA, 0, 0, 0);
		add_cmd(OP_FLOYD, 0, 0, 0);
		drain();
		set_config(15, 1);
		add_cmd(OP_FLOYD, 0, 0, 0);
		drain();

		// random phases, mostly small graphs
		for (int p = 0; p < 16; p++) begin
			nodes = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
			if (p == 0) nodes = 1;
			if (p == 1) nodes = 8;
			set_config(nodes, $urandom_range(0, 1));
			random_phase($urandom_range(8, 20));
			drain();
		end

		$display("ran %0d commands over %0d settings: %0d dijkstra, %0d floyd-warshall runs",
			n_cmds, n_phases, n_dj, n_fw);
		$display("checked %0d result words, %0d mismatches", n_results, n_mismatch);
		if (n_mismatch == 0 && expected_words.size() == 0)
			$display("shortest_path_engine_top regression: pass");
		else
			$display("shortest_path_engine_top regression: fail");
		$finish;
	end

endmodule
